// ===== rtl/core/ring_queue_with_front_insert_assert.svh =====
`ifndef RING_QUEUE_WITH_FRONT_INSERT_ASSERT_SVH
`define RING_QUEUE_WITH_FRONT_INSERT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RQFI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RQFI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rqfi_pkg.sv =====
package rqfi_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int MSG_BITS  = 32;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 7;
    localparam int OCC_W  = 6;

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int LEN_W = $clog2(MAX_SLOTS + 1);
    localparam int MEM_W = (MSG_BITS < DATA_W) ? MSG_BITS : DATA_W;
    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'((MAX_SLOTS < 64) ? MAX_SLOTS : 64);
    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);

    typedef enum logic [1:0] {
        OP_SEND  = 2'd0,
        OP_RECV  = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    // Clamp a written ring length into 2..MAX_SLOTS.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(v);
        if (wide < CMP_W'(2)) begin
            return LEN_MIN;
        end else if (wide > CMP_W'(MAX_SLOTS)) begin
            return LEN_W'(MAX_SLOTS);
        end else begin
            return LEN_W'(wide);
        end
    endfunction

endpackage

// ===== rtl/core/ring_queue_with_front_insert.sv =====
// Message queue in a ring of queue_length slots (capacity queue_length - 1), with normal
// sends at the tail and priority sends at the head. The block takes one command per clock
// (busy never rises) and answers each one in the next cycle with a single-cycle
// o_res_strobe, registered to match the registered read port of the slot memory,
// which a receive must go through. The receiver cannot stall, so sample the result on
// the strobe cycle or lose it. Writing queue_length empties the queue and takes effect
// on the next command; the write waits while start is high, and should only be made
// when no result is still due. Out-of-range lengths clamp to 2..MAX_SLOTS. No clearing
// pass runs after reset: slots are only read once a send has filled them.
module ring_queue_with_front_insert
    import rqfi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_opcode,
    input  logic              i_priority_req,
    input  logic [DATA_W-1:0] i_message_in,

    output logic              o_res_strobe,
    output logic              o_done_res,
    output logic [DATA_W-1:0] o_message_out,
    output logic [OCC_W-1:0]  o_occupancy,

    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_queue_length
);

`include "ring_queue_with_front_insert_assert.svh"

    // ring pointers and length
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [LEN_W-1:0] r_len,  n_len;

    // result stage
    logic             r_res_strobe;
    logic             r_done, n_done;
    logic             r_pop_ok, n_pop_ok;
    logic [IDX_W-1:0] r_occ, n_occ;

    // memory port controls
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic             mem_re;
    logic [MEM_W-1:0] mem_rdata;

    logic             accept;
    logic             cfg_wr;
    logic [IDX_W-1:0] held;
    logic             full;
    logic             empty;
    logic [LEN_W-1:0] head_ext;
    logic [LEN_W-1:0] tail_ext;
    logic [LEN_W-1:0] head_inc;
    logic [LEN_W-1:0] tail_inc;

    // Always open for commands; hold off a length write while a command is offered.
    assign busy        = 1'b0;
    assign o_cfg_ready = !start;

    assign accept = start && !busy;
    assign cfg_wr = i_cfg_valid && o_cfg_ready;

    assign head_ext = LEN_W'(r_head);
    assign tail_ext = LEN_W'(r_tail);
    assign head_inc = head_ext + LEN_W'(1);
    assign tail_inc = tail_ext + LEN_W'(1);

    // Occupancy is (tail - head) mod length; both pointers stay below length.
    always_comb begin
        logic [LEN_W-1:0] diff;
        if (tail_ext >= head_ext) begin
            diff = tail_ext - head_ext;
        end else begin
            diff = tail_ext + r_len - head_ext;
        end
        held  = diff[IDX_W-1:0];
        full  = (diff == r_len - LEN_W'(1));
        empty = (diff == '0);
    end

    // Decode the command, advance pointers, drive the memory ports.
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_len    = r_len;
        n_done   = 1'b0;
        n_pop_ok = 1'b0;
        n_occ    = held;
        mem_we   = 1'b0;
        mem_waddr = r_tail;
        mem_re   = 1'b0;

        priority if (cfg_wr) begin
            // new ring: drop everything and restart at slot zero
            n_len  = clamp_len(i_cfg_queue_length);
            n_head = '0;
            n_tail = '0;
        end else if (accept) begin
            unique case (t_opcode'(i_opcode))
                OP_SEND: begin
                    if (!full) begin
                        n_done = 1'b1;
                        n_occ  = held + IDX_W'(1);
                        mem_we = 1'b1;
                        if (!i_priority_req) begin
                            // write at tail, advance tail with wrap
                            mem_waddr = r_tail;
                            n_tail    = (tail_inc >= r_len) ? '0 : r_tail + IDX_W'(1);
                        end else begin
                            // step head back with wrap, write there
                            if (r_head == '0) begin
                                n_head = IDX_W'(r_len - LEN_W'(1));
                            end else begin
                                n_head = r_head - IDX_W'(1);
                            end
                            mem_waddr = n_head;
                        end
                    end
                end
                OP_RECV: begin
                    if (!empty) begin
                        // read head now, data lands with the result strobe
                        n_done   = 1'b1;
                        n_pop_ok = 1'b1;
                        n_occ    = held - IDX_W'(1);
                        mem_re   = 1'b1;
                        n_head   = (head_inc >= r_len) ? '0 : r_head + IDX_W'(1);
                    end
                end
                OP_CLEAR: begin
                    n_done = 1'b1;
                    n_occ  = '0;
                    n_head = '0;
                    n_tail = '0;
                end
                default: begin
                    // unused code: no change, report occupancy
                end
            endcase
        end else begin
            // idle: hold pointers and length
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_len        <= LEN_RESET;
            r_res_strobe <= 1'b0;
        end else begin
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_len        <= n_len;
            r_res_strobe <= accept && !cfg_wr;
        end
    end

    // result payload: hold until the next transfer overwrites it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_done   <= n_done;
            r_pop_ok <= n_pop_ok;
            r_occ    <= n_occ;
        end
    end

    rqfi_ram #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (MEM_W)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_message_in[MEM_W-1:0]),
        .i_re    (mem_re),
        .i_raddr (r_head),
        .o_rdata (mem_rdata)
    );

    assign o_res_strobe  = r_res_strobe;
    assign o_done_res    = r_done;
    assign o_message_out = r_pop_ok ? DATA_W'(mem_rdata) : '0;
    assign o_occupancy   = OCC_W'(r_occ);

    `RQFI_ASSERT_NEXT(a_strobe_follows_cmd, i_clk, i_rst_n, accept && !cfg_wr,
        o_res_strobe, "command transfer without result strobe")
    `RQFI_ASSERT_NEXT(a_no_spurious_strobe, i_clk, i_rst_n, !accept,
        !o_res_strobe, "result strobe without command transfer")
    `RQFI_ASSERT_NOW(a_ptrs_in_ring, i_clk, i_rst_n, 1'b1,
        (head_ext < r_len) && (tail_ext < r_len), "ring pointer beyond length")
    `RQFI_ASSERT_NOW(a_pop_only_on_done, i_clk, i_rst_n,
        o_res_strobe && (o_message_out != '0), o_done_res, "message out on refused command")
    `RQFI_ASSERT_NEXT(a_full_send_refused, i_clk, i_rst_n,
        accept && !cfg_wr && full && (i_opcode == OP_SEND), !o_done_res,
        "send into full queue accepted")

endmodule

// ===== rtl/core/rqfi_ram.sv =====
module rqfi_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Testbench for ring_queue_with_front_insert.
// An in-bench model of the ring (slot words, head and tail, length register) predicts
// the reply to every accepted command. A checker process compares each strobed reply,
// field by field, with the oldest prediction. The test tasks cover these areas in turn:
// plain and priority sends and receives at the reset length, the clamped two-slot ring,
// a ring filled to capacity, and random traffic over many ring lengths with gaps between
// commands.
module tb;
    import rqfi_pkg::*;

    // Opcode value that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Idle cycles to let pass after the last reply before touching the length register.
    localparam int DRAIN_SLACK = 4;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] word;
        logic [OCC_W-1:0]  occ;
    } t_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_opcode = OP_SEND;
    logic              i_priority_req = 1'b0;
    logic [DATA_W-1:0] i_message_in = '0;
    logic              o_res_strobe;
    logic              o_done_res;
    logic [DATA_W-1:0] o_message_out;
    logic [OCC_W-1:0]  o_occupancy;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_queue_length = '0;

    // Ring model: slot words, indices and the raw length register.
    logic [DATA_W-1:0] ring_words [MAX_SLOTS];
    int unsigned       ring_tail = 0;
    int unsigned       ring_head = 0;
    logic [CFG_W-1:0]  ring_len_reg = CFG_W'(64);

    // Replies predicted but not yet seen on the result ports, oldest first.
    t_reply            due_replies [$];
    int                errors = 0;
    bit                allow_gaps = 1'b1;

    ring_queue_with_front_insert uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_priority_req     (i_priority_req),
        .i_message_in       (i_message_in),
        .o_res_strobe       (o_res_strobe),
        .o_done_res         (o_done_res),
        .o_message_out      (o_message_out),
        .o_occupancy        (o_occupancy),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_queue_length (i_cfg_queue_length)
    );

    always #5 i_clk = ~i_clk;

    // Clamp the length register into the legal ring sizes.
    function automatic int unsigned ring_len();
        int unsigned l;
        l = ring_len_reg;
        if (l < 2) l = 2;
        if (l > MAX_SLOTS) l = MAX_SLOTS;
        return l;
    endfunction

    function automatic int unsigned ring_held(int unsigned len);
        return (ring_tail + len - ring_head) % len;
    endfunction

    // Advance the ring model by one accepted command and queue the reply it must give.
    function automatic void apply_command(logic [1:0] op, logic pri, logic [DATA_W-1:0] msg);
        int unsigned len;
        t_reply      r;
        len = ring_len();
        r = '0;
        if (ring_head >= len) ring_head = 0;
        if (ring_tail >= len) ring_tail = 0;
        case (op)
            OP_SEND: begin
                if (ring_held(len) < len - 1) begin
                    if (!pri) begin
                        ring_words[ring_tail] = msg;
                        ring_tail = (ring_tail + 1 >= len) ? 0 : ring_tail + 1;
                    end else begin
                        // Step the head back with wraparound and write there.
                        ring_head = (ring_head == 0) ? len - 1 : ring_head - 1;
                        ring_words[ring_head] = msg;
                    end
                    r.done = 1'b1;
                end
            end
            OP_RECV: begin
                if (ring_held(len) > 0) begin
                    r.word = ring_words[ring_head];
                    ring_head = (ring_head + 1 >= len) ? 0 : ring_head + 1;
                    r.done = 1'b1;
                end
            end
            OP_CLEAR: begin
                ring_tail = 0;
                ring_head = 0;
                r.done = 1'b1;
            end
            default: ;
        endcase
        r.occ = OCC_W'(ring_held(len));
        due_replies.push_back(r);
    endfunction

    // Present one command and hold it until the transfer happens; leave start high so a
    // following command goes out back to back.
    task automatic send_cmd(logic [1:0] op, logic pri, logic [DATA_W-1:0] msg);
        i_opcode <= op;
        i_priority_req <= pri;
        i_message_in <= msg;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        apply_command(op, pri, msg);
    endtask

    task automatic pause_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Insert an idle burst now and then, while gaps are allowed.
    task automatic maybe_gap();
        if (allow_gaps && $urandom_range(0, 7) == 0)
            pause_cycles($urandom_range(1, 19));
    endtask

    // Hold off commands until every predicted reply has come, then let the pipe settle.
    task automatic wait_drained();
        start <= 1'b0;
        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // Write the ring length while idle; the block empties the queue on this write.
    task automatic write_length(logic [CFG_W-1:0] v);
        wait_drained();
        i_cfg_queue_length <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ring_len_reg = v;
        ring_tail = 0;
        ring_head = 0;
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly sends or receives by the given send share, a few clears and unused opcodes.
    function automatic logic [1:0] pick_op(int send_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < send_pct) return OP_SEND;
        if (r < 98) return OP_RECV;
        if (r < 99) return OP_CLEAR;
        return OP_UNUSED;
    endfunction

    // Reset length: ordering of plain and priority sends, refusals, ignored fields.
    task automatic test_basic_ops();
        send_cmd(OP_RECV, 1'b0, '0);                  // receive from empty queue
        send_cmd(OP_SEND, 1'b0, '0);
        send_cmd(OP_SEND, 1'b0, '1);
        send_cmd(OP_SEND, 1'b1, 32'hA5A5_5A5A);       // jumps ahead of both
        send_cmd(OP_RECV, 1'b0, '1);
        send_cmd(OP_RECV, 1'b0, '0);
        send_cmd(OP_UNUSED, 1'b1, 32'hDEAD_BEEF);     // unused opcode leaves state alone
        send_cmd(OP_RECV, 1'b1, 32'h1234_5678);       // priority flag ignored on receive
        send_cmd(OP_RECV, 1'b0, '0);
        send_cmd(OP_SEND, 1'b0, 32'h0F0F_F0F0);
        send_cmd(OP_SEND, 1'b1, 32'hF0F0_0F0F);
        send_cmd(OP_CLEAR, 1'b1, '1);                 // priority flag ignored on clear
        send_cmd(OP_RECV, 1'b0, '0);
        send_cmd(OP_SEND, 1'b1, 32'h8000_0001);       // head wraps back past slot zero
        send_cmd(OP_SEND, 1'b0, 32'h7FFF_FFFE);
        send_cmd(OP_SEND, 1'b1, 32'h5555_AAAA);
        send_cmd(OP_RECV, 1'b0, '0);
        send_cmd(OP_RECV, 1'b0, '0);
        send_cmd(OP_RECV, 1'b0, '0);
        send_cmd(OP_UNUSED, 1'b0, '0);
    endtask

    // Lengths below two clamp to a two-slot ring holding one message.
    task automatic test_tiny_ring();
        write_length(CFG_W'(0));
        send_cmd(OP_SEND, 1'b0, 32'h0000_00AA);
        send_cmd(OP_SEND, 1'b0, 32'h0000_00BB);       // full: refused
        send_cmd(OP_SEND, 1'b1, 32'h0000_00CC);       // full: priority refused too
        send_cmd(OP_RECV, 1'b0, '0);
        send_cmd(OP_SEND, 1'b1, 32'h0000_00DD);
        send_cmd(OP_RECV, 1'b0, '0);
        send_cmd(OP_RECV, 1'b0, '0);
        write_length(CFG_W'(1));
        send_cmd(OP_SEND, 1'b1, '1);
        send_cmd(OP_SEND, 1'b0, '0);
        send_cmd(OP_RECV, 1'b0, '0);
        write_length(CFG_W'(2));
        send_cmd(OP_SEND, 1'b0, 32'h1357_9BDF);
        send_cmd(OP_RECV, 1'b0, '0);
    endtask

    // Largest register value clamps to the full ring; fill it, overflow, drain it.
    task automatic test_full_ring();
        write_length('1);
        for (int i = 0; i < MAX_SLOTS - 1; i++)
            send_cmd(OP_SEND, 1'($urandom_range(0, 1)), $urandom);
        send_cmd(OP_SEND, 1'b0, '1);
        send_cmd(OP_SEND, 1'b1, '1);
        for (int i = 0; i < MAX_SLOTS; i++)
            send_cmd(OP_RECV, 1'b0, '0);
        write_length(CFG_W'(65));
        send_cmd(OP_SEND, 1'b0, 32'hCAFE_F00D);
        send_cmd(OP_RECV, 1'b0, '0);
    endtask

    // Random traffic: each phase picks a ring length, fills hard, then drains hard.
    task automatic test_random_traffic();
        int n_items;
        int send_pct;
        for (int p = 0; p < 10; p++) begin
            case (p)
                0:       write_length(CFG_W'(2));
                1:       write_length(CFG_W'(3));
                2:       write_length(CFG_W'($urandom_range(4, 9)));
                3:       write_length(CFG_W'(0));
                4:       write_length('1);
                5:       write_length(CFG_W'($urandom_range(0, 127)));
                6:       write_length(CFG_W'(5));
                7:       write_length(CFG_W'(64));
                8:       write_length(CFG_W'($urandom_range(2, 16)));
                default: write_length(CFG_W'($urandom_range(2, 8)));
            endcase
            // Drop the gaps for the last stretch so commands run back to back.
            allow_gaps = (p < 8);
            n_items = (p == 4) ? 160 : 56;
            for (int i = 0; i < n_items; i++) begin
                send_pct = (i < n_items * 2 / 3) ? 80 : 25;
                // Hold the sender once mid-phase until every reply is back.
                if (p == 6 && i == n_items / 2)
                    wait_drained();
                maybe_gap();
                send_cmd(pick_op(send_pct), 1'($urandom_range(0, 1)), pick_word());
            end
        end
    endtask

    // Compare each strobed reply with the oldest prediction.
    always @(posedge i_clk) begin : check_reply
        t_reply want;
        if (i_rst_n && o_res_strobe) begin
            if (due_replies.size() == 0) begin
                errors++;
                $display("%0t: reply with none expected: done=%0b word=%h occ=%0d",
                         $time, o_done_res, o_message_out, o_occupancy);
            end else begin
                want = due_replies.pop_front();
                if (o_done_res !== want.done) begin
                    errors++;
                    $display("%0t: done expected %0b actual %0b",
                             $time, want.done, o_done_res);
                end
                if (o_message_out !== want.word) begin
                    errors++;
                    $display("%0t: message expected %h actual %h",
                             $time, want.word, o_message_out);
                end
                if (o_occupancy !== want.occ) begin
                    errors++;
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occ, o_occupancy);
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_tiny_ring();
        test_full_ring();
        test_random_traffic();

        wait_drained();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
